// File: src/wpm_pkg.sv
// wpm_pkg: shared constants, configuration codes and control structs
// for the waypoint spacing marker. No dependencies; compiled first.

package wpm_pkg;

    // point geometry
    localparam int MAX_DIMS   = 5;
    localparam int COORD_W    = 32;
    localparam int IDX_W      = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int CNT_W      = $clog2(MAX_DIMS + 2);

    // distance arithmetic
    localparam int SQ_W       = 2 * COORD_W;
    localparam int SUM_W      = SQ_W + ((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 0);
    localparam int ROOT_W     = (SUM_W + 1) / 2;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 3;
    localparam int RCNT_W     = $clog2(ROOT_W);
    localparam int DIST_W     = 40;

    // configuration registers
    localparam int SPACING_W  = 32;
    localparam int DIMS_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPACING = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS_USED   = CFG_IDX_W'(1);

    localparam logic [SPACING_W-1:0] MIN_SPACING_RST = SPACING_W'(98304);
    localparam logic [DIMS_W-1:0]    DIMS_USED_RST   = DIMS_W'(3);

    // flips the sign bit so unsigned differences equal signed ones
    localparam logic [COORD_W-1:0] COORD_OFFSET = {1'b1, {(COORD_W-1){1'b0}}};

    // controller to datapath
    typedef struct packed {
        logic             load;
        logic             sq_en;
        logic [IDX_W-1:0] idx;
        logic             root_load;
        logic             root_step;
        logic             commit;
    } wpm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic             seg_need;
        logic [CNT_W-1:0] dims;
        logic             out_valid;
    } wpm_status_t;

endpackage

// File: src/wpm_point_if.sv
// wpm_point_if / wpm_result_if: valid/ready request channels for path
// points and marking results. Depends on wpm_pkg.

interface wpm_point_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [wpm_pkg::COORD_W-1:0]   coord_0;
    logic signed [wpm_pkg::COORD_W-1:0]   coord_1;
    logic signed [wpm_pkg::COORD_W-1:0]   coord_2;
    logic signed [wpm_pkg::COORD_W-1:0]   coord_3;
    logic signed [wpm_pkg::COORD_W-1:0]   coord_4;
    logic                                 fixed_in;
    logic                                 path_start;

    modport source (
        output valid, coord_0, coord_1, coord_2, coord_3, coord_4, fixed_in, path_start,
        input  ready
    );
    modport sink (
        input  valid, coord_0, coord_1, coord_2, coord_3, coord_4, fixed_in, path_start,
        output ready
    );
endinterface

interface wpm_result_if;
    logic                          valid;
    logic                          ready;
    logic                          fixed_out;
    logic                          is_anchor;
    logic [wpm_pkg::DIST_W-1:0]    distance_since_anchor;

    modport source (
        output valid, fixed_out, is_anchor, distance_since_anchor,
        input  ready
    );
    modport sink (
        input  valid, fixed_out, is_anchor, distance_since_anchor,
        output ready
    );
endinterface

// File: src/waypoint_min_spacing_marker.sv
// waypoint_min_spacing_marker: top level joining the sequencer and datapath.
// Depends on wpm_pkg, wpm_point_if, wpm_result_if, wpm_ctrl, wpm_datapath.
//
// Usage:
//   pt  : point request channel (valid/ready), up to five signed Q16.16
//         coordinates plus fixed_in and path_start
//   res : result request channel (valid/ready), fixed_out, is_anchor and
//         the 40-bit saturating distance since the last anchor
//   cfg : write-only port, index 0 min_spacing, index 1 dims_used;
//         write only while no point is in flight
// Sequence: with a segment to measure, a point runs the dims_used squaring
//   steps, the drain of the difference and square stages, root load, one
//   root iteration per result bit and commit; a path start or a point before
//   any anchor skips the squaring and root and goes to commit. One point is
//   worked on at a time and the next is taken in the cycle after commit, so
//   the bit-serial root sets the rate at which points are taken.
// Reset: clears the anchor and distance and loads min_spacing = 1.5 and
//   dims_used = 3; no clearing pass.
// Stall: the result sits in an output register; the next point is
//   accepted and computed meanwhile and waits at commit until res is taken.

module waypoint_min_spacing_marker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [wpm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wpm_pkg::CFG_DATA_W-1:0]   cfg_data,
    wpm_point_if.sink                        pt,
    wpm_result_if.source                     res
);
    import wpm_pkg::*;

    wpm_cmd_t                             cmd;
    wpm_status_t                          status;
    logic [MAX_DIMS-1:0][COORD_W-1:0]     coords;

    // coordinate fields into one vector
    assign coords[0] = pt.coord_0;
    assign coords[1] = pt.coord_1;
    assign coords[2] = pt.coord_2;
    assign coords[3] = pt.coord_3;
    assign coords[4] = pt.coord_4;

    // sequencer
    wpm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pt.valid),
        .in_ready  (pt.ready),
        .out_ready (res.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath
    wpm_datapath u_datapath (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg_we                (cfg_we),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .coords                (coords),
        .fixed_in              (pt.fixed_in),
        .path_start            (pt.path_start),
        .cmd                   (cmd),
        .status                (status),
        .out_ready             (res.ready),
        .out_valid             (res.valid),
        .fixed_out             (res.fixed_out),
        .is_anchor             (res.is_anchor),
        .distance_since_anchor (res.distance_since_anchor)
    );

endmodule

// File: src/wpm_ctrl.sv
// wpm_ctrl: sequencer for one point: squaring pass, bit-serial root,
// then commit to the output register. Depends on wpm_pkg.

module wpm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  out_ready,
    input  wpm_pkg::wpm_status_t  status,
    output wpm_pkg::wpm_cmd_t     cmd
);
    import wpm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_ROOT_LOAD,
        S_ROOT,
        S_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [RCNT_W-1:0]   rcnt_reg, rcnt_next;
    logic                out_free;

    assign out_free = !status.out_valid || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        rcnt_next     = rcnt_reg;
        cmd           = '0;
        cmd.idx       = cnt_reg[IDX_W-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                if (!status.seg_need)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.sq_en = (cnt_reg < status.dims);
                    // counting on past dims drains the difference and square stages
                    if (cnt_reg == status.dims + CNT_W'(1))
                    begin
                        state_next = S_ROOT_LOAD;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
            S_ROOT_LOAD:
            begin
                cmd.root_load = 1'b1;
                rcnt_next     = RCNT_W'(ROOT_W - 1);
                state_next    = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (rcnt_reg == '0)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    rcnt_next = rcnt_reg - RCNT_W'(1);
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            rcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rcnt_reg  <= rcnt_next;
        end
    end

    // accepted point always starts the squaring pass
    a_load_to_square: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_SQUARE)
        else $error("accepted point did not enter squaring pass");

    // root iteration ends after its last bit
    a_root_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROOT && rcnt_reg == '0) |=> state_reg == S_FINISH)
        else $error("root iteration overran");

    // points without a segment skip straight to commit
    a_skip_segment: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQUARE && !status.seg_need) |=> state_reg == S_FINISH)
        else $error("segment computed without an anchor");

endmodule

// File: src/wpm_datapath.sv
// wpm_datapath: configuration registers, point state, squared-difference
// accumulator, bit-serial square root and output register. Depends on wpm_pkg.

module wpm_datapath (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            cfg_we,
    input  logic [wpm_pkg::CFG_IDX_W-1:0]                   cfg_index,
    input  logic [wpm_pkg::CFG_DATA_W-1:0]                  cfg_data,
    input  logic [wpm_pkg::MAX_DIMS-1:0][wpm_pkg::COORD_W-1:0] coords,
    input  logic                                            fixed_in,
    input  logic                                            path_start,
    input  wpm_pkg::wpm_cmd_t                               cmd,
    output wpm_pkg::wpm_status_t                            status,
    input  logic                                            out_ready,
    output logic                                            out_valid,
    output logic                                            fixed_out,
    output logic                                            is_anchor,
    output logic [wpm_pkg::DIST_W-1:0]                      distance_since_anchor
);
    import wpm_pkg::*;

    logic [SPACING_W-1:0]  min_spacing_reg;
    logic [DIMS_W-1:0]     dims_used_reg;

    logic                  anchor_seen_reg;
    logic [DIST_W-1:0]     run_reg;
    logic [COORD_W-1:0]    prev_reg [MAX_DIMS];
    logic [COORD_W-1:0]    cur_reg  [MAX_DIMS];
    logic                  fixed_in_reg;
    logic                  path_start_reg;

    logic [COORD_W-1:0]    d_reg;
    logic                  d_vld_reg;
    logic [SQ_W-1:0]       sq_reg;
    logic                  sq_vld_reg;
    logic [SUM_W-1:0]      sum_reg;

    logic [RAD_W-1:0]      rad_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [ROOT_W-1:0]     root_reg;

    logic                  out_valid_reg;
    logic                  fixed_out_reg;
    logic                  is_anchor_reg;
    logic [DIST_W-1:0]     dist_out_reg;

    logic [CNT_W-1:0]      dims_clamp;
    logic [COORD_W-1:0]    cur_sel;
    logic [COORD_W-1:0]    prev_sel;
    logic [COORD_W-1:0]    diff_abs;
    logic [REM_W-1:0]      rem_sh;
    logic [REM_W-1:0]      trial;
    logic [DIST_W:0]       dist_sum;
    logic [DIST_W-1:0]     run_pre;
    logic                  anchor_eff;
    logic                  make_anchor;

    // clamp of the dimension count
    always_comb
    begin
        if (dims_used_reg > DIMS_W'(MAX_DIMS))
        begin
            dims_clamp = CNT_W'(MAX_DIMS);
        end
        else
        begin
            dims_clamp = CNT_W'(dims_used_reg);
        end
    end

    assign status.dims      = dims_clamp;
    assign status.seg_need  = !path_start_reg && anchor_seen_reg;
    assign status.out_valid = out_valid_reg;

    // absolute coordinate difference for the selected dimension
    assign cur_sel  = cur_reg[cmd.idx];
    assign prev_sel = prev_reg[cmd.idx];
    assign diff_abs = (cur_sel >= prev_sel) ? (cur_sel - prev_sel) : (prev_sel - cur_sel);

    // one restoring square-root step
    assign rem_sh = {rem_reg[ROOT_W:0], rad_reg[RAD_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};

    // saturating distance update and anchor decision
    always_comb
    begin
        dist_sum = {1'b0, run_reg} + (DIST_W+1)'(root_reg);
        if (path_start_reg)
        begin
            run_pre    = '0;
            anchor_eff = 1'b0;
        end
        else if (anchor_seen_reg)
        begin
            run_pre    = dist_sum[DIST_W] ? {DIST_W{1'b1}} : dist_sum[DIST_W-1:0];
            anchor_eff = 1'b1;
        end
        else
        begin
            run_pre    = run_reg;
            anchor_eff = 1'b0;
        end
        make_anchor = !fixed_in_reg &&
                      (!anchor_eff || run_pre > DIST_W'(min_spacing_reg));
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_spacing_reg <= MIN_SPACING_RST;
            dims_used_reg   <= DIMS_USED_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_SPACING: min_spacing_reg <= cfg_data[SPACING_W-1:0];
                CFG_DIMS_USED:   dims_used_reg   <= cfg_data[DIMS_W-1:0];
                default:         ;
            endcase
        end
    end

    // path state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anchor_seen_reg <= 1'b0;
            run_reg         <= '0;
            out_valid_reg   <= 1'b0;
            d_vld_reg       <= 1'b0;
            sq_vld_reg      <= 1'b0;
        end
        else
        begin
            d_vld_reg  <= cmd.sq_en;
            sq_vld_reg <= d_vld_reg;
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
                if (make_anchor)
                begin
                    anchor_seen_reg <= 1'b1;
                    run_reg         <= '0;
                end
                else
                begin
                    anchor_seen_reg <= anchor_eff;
                    run_reg         <= run_pre;
                end
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload: point capture, squaring pipeline, root iteration, results
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < MAX_DIMS; i++)
            begin
                cur_reg[i] <= coords[i] ^ COORD_OFFSET;
            end
            fixed_in_reg   <= fixed_in;
            path_start_reg <= path_start;
            sum_reg        <= '0;
        end
        else if (sq_vld_reg)
        begin
            sum_reg <= sum_reg + SUM_W'(sq_reg);
        end

        d_reg  <= diff_abs;
        sq_reg <= SQ_W'(d_reg) * SQ_W'(d_reg);

        if (cmd.root_load)
        begin
            rad_reg  <= RAD_W'(sum_reg);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.root_step)
        begin
            rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end

        if (cmd.commit)
        begin
            for (int i = 0; i < MAX_DIMS; i++)
            begin
                prev_reg[i] <= cur_reg[i];
            end
            fixed_out_reg <= fixed_in_reg || !make_anchor;
            is_anchor_reg <= make_anchor;
            dist_out_reg  <= run_pre;
        end
    end

    assign out_valid             = out_valid_reg;
    assign fixed_out             = fixed_out_reg;
    assign is_anchor             = is_anchor_reg;
    assign distance_since_anchor = dist_out_reg;

    // no distance accumulates before an anchor exists
    a_no_anchor_no_dist: assert property (@(posedge clk) disable iff (!rst_n)
        !anchor_seen_reg |-> run_reg == '0)
        else $error("running distance without anchor");

    // commit never overwrites an untaken result
    a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("result overwritten");

    // a new anchor is never reported as fixed
    a_anchor_not_fixed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(is_anchor_reg && fixed_out_reg))
        else $error("anchor marked fixed");

endmodule
